[design/swv_pkg.sv]
// ----------------------------------------------------------------------------
// swv_pkg: shared definitions for the sliding window variance block
// Widths, storage sizes, action codes and the job record passed from the
// window front end to the variance back end.
// ----------------------------------------------------------------------------
package swv_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int POS_W       = $clog2(MAX_WINDOW);
    localparam int LEN_W       = 7;
    localparam int SAMPLE_W    = 24;
    localparam int SUM_W       = SAMPLE_W + POS_W;
    localparam int SQR_W       = 2 * SAMPLE_W;
    localparam int SQ_W        = SQR_W + POS_W + 1;
    localparam int PROD_W      = SQ_W + LEN_W;
    localparam int NUM_W       = PROD_W + (PROD_W % 2);
    localparam int VAR_W       = 47;
    localparam int DVS_W       = 2 * LEN_W;

    localparam logic [LEN_W-1:0] LEN_RESET = 7'd7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int DIV_BITS    = 2;
    localparam int DIV_CYCLES  = NUM_W / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);

    typedef enum logic {
        ACT_UPDATE   = 1'b0,
        ACT_ESTIMATE = 1'b1
    } t_action;

    // Window totals for one item, including its sample.
    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
        logic [LEN_W-1:0]        len;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SQUARE,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_SUB,
        B_DIV,
        B_OUT
    } t_back_state;

endpackage

[design/swv_front.sv]
// ----------------------------------------------------------------------------
// swv_front: window store and running totals
// Accepts a sample, reads the entry it replaces, forms the window sum and
// sum of squares, queues them and commits the sample for an update.
// ----------------------------------------------------------------------------
module swv_front import swv_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [LEN_W-1:0]           i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_push,
    output t_job                       o_job,
    input  logic                       i_full
);

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (v > LEN_W'(MAX_WINDOW)) begin
            r = LEN_W'(MAX_WINDOW);
        end else begin
            r = v;
        end
        return r;
    endfunction

    t_front_state r_state, n_state;

    logic [SAMPLE_W-1:0]        r_mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]      r_valid;
    logic [LEN_W-1:0]           r_len;
    logic [POS_W-1:0]           r_pos;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQ_W-1:0]            r_sq;

    logic signed [SAMPLE_W-1:0] r_x;
    logic                       r_act;
    logic [POS_W-1:0]           r_addr;
    logic [SAMPLE_W-1:0]        r_rd_data;
    logic                       r_rd_ok;
    logic signed [SAMPLE_W-1:0] r_old;
    logic [SQR_W-1:0]           r_old_sq;
    logic [SQR_W-1:0]           r_x_sq;

    logic                       accept;
    logic                       commit;
    logic [POS_W-1:0]           rd_addr;
    logic signed [SAMPLE_W-1:0] old_val;
    logic signed [SUM_W-1:0]    n_sum;
    logic [SQ_W-1:0]            n_sq;
    logic [LEN_W-1:0]           pos_inc;
    logic [POS_W-1:0]           n_pos;

    assign accept  = i_in_valid && !o_in_stall;
    assign rd_addr = (LEN_W'(r_pos) >= r_len) ? '0 : r_pos;
    assign old_val = r_rd_ok ? $signed(r_rd_data) : '0;
    assign n_sum   = r_sum - {{POS_W{r_old[SAMPLE_W-1]}}, r_old}
                           + {{POS_W{r_x[SAMPLE_W-1]}}, r_x};
    assign n_sq    = r_sq - SQ_W'(r_old_sq) + SQ_W'(r_x_sq);
    assign pos_inc = LEN_W'(r_addr) + LEN_W'(1);
    assign n_pos   = (pos_inc >= r_len) ? '0 : pos_inc[POS_W-1:0];
    assign commit  = o_push && (r_act == ACT_UPDATE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) n_state = F_SQUARE;
            end
            F_SQUARE: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) n_state = F_IDLE;
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != F_IDLE);
        o_push     = (r_state == F_PUSH) && !i_full;
    end

    assign o_job.sum = n_sum;
    assign o_job.sq  = n_sq;
    assign o_job.len = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_len   <= LEN_RESET;
            r_pos   <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                // A new window length starts a fresh, all-zero window.
                r_len   <= clamp_len(i_cfg_wr_data);
                r_pos   <= '0;
                r_sum   <= '0;
                r_sq    <= '0;
                r_valid <= '0;
            end else if (commit) begin
                r_pos           <= n_pos;
                r_sum           <= n_sum;
                r_sq            <= n_sq;
                r_valid[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
        if (commit) begin
            r_mem[r_addr] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x     <= i_sample;
            r_act   <= i_action;
            r_addr  <= rd_addr;
            r_rd_ok <= r_valid[rd_addr];
        end
        if (r_state == F_SQUARE) begin
            r_old    <= old_val;
            r_old_sq <= SQR_W'(old_val * old_val);
            r_x_sq   <= SQR_W'(r_x * r_x);
        end
    end

endmodule

[design/swv_queue.sv]
// ----------------------------------------------------------------------------
// swv_queue: job queue between front end and back end
// A small first-in first-out store of window totals awaiting division.
// ----------------------------------------------------------------------------
module swv_queue import swv_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    t_job              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

endmodule

[design/swv_back.sv]
// ----------------------------------------------------------------------------
// swv_back: variance arithmetic
// Forms N*sum(x^2) - sum^2, divides it by N^2 two quotient bits per cycle
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module swv_back import swv_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_job             i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [VAR_W-1:0] o_variance
);

    t_back_state             r_state, n_state;

    logic signed [SUM_W-1:0] r_s;
    logic [SQ_W-1:0]         r_s2;
    logic [LEN_W-1:0]        r_n;
    logic [NUM_W-1:0]        r_prod_a;
    logic [NUM_W-1:0]        r_prod_b;
    logic [DVS_W-1:0]        r_dvs;
    logic [DVS_W-1:0]        r_rem;
    logic [NUM_W-1:0]        r_quo;
    logic [DIV_CNT_W-1:0]    r_cnt;

    logic [SUM_W-1:0]        mag;
    logic [DVS_W-1:0]        step_rem;
    logic [NUM_W-1:0]        step_quo;
    logic [DVS_W:0]          rem_sh;

    assign mag = r_s[SUM_W-1] ? SUM_W'(-r_s) : SUM_W'(r_s);

    // Restoring division: the numerator shifts out of the top of r_quo while
    // quotient bits enter at the bottom.
    always_comb begin
        step_rem = r_rem;
        step_quo = r_quo;
        rem_sh   = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            rem_sh   = {step_rem, step_quo[NUM_W-1]};
            step_quo = {step_quo[NUM_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, r_dvs}) begin
                rem_sh      = rem_sh - {1'b0, r_dvs};
                step_quo[0] = 1'b1;
            end
            step_rem = rem_sh[DVS_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_empty) n_state = B_MUL;
            end
            B_MUL: begin
                n_state = B_SUB;
            end
            B_SUB: begin
                n_state = B_DIV;
            end
            B_DIV: begin
                if (r_cnt == DIV_CNT_W'(1)) n_state = B_OUT;
            end
            B_OUT: begin
                if (!i_out_stall) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = (r_state == B_IDLE) && !i_empty;
        o_out_valid = (r_state == B_OUT);
        o_variance  = r_quo[VAR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s  <= i_job.sum;
            r_s2 <= i_job.sq;
            r_n  <= i_job.len;
        end
        if (r_state == B_MUL) begin
            r_prod_a <= NUM_W'(r_s2 * r_n);
            r_prod_b <= NUM_W'(mag * mag);
            r_dvs    <= DVS_W'(r_n * r_n);
        end
        if (r_state == B_SUB) begin
            r_quo <= r_prod_a - r_prod_b;
            r_rem <= '0;
            r_cnt <= DIV_CNT_W'(DIV_CYCLES);
        end
        if (r_state == B_DIV) begin
            r_quo <= step_quo;
            r_rem <= step_rem;
            r_cnt <= r_cnt - DIV_CNT_W'(1);
        end
    end

endmodule

[design/sliding_window_variance.sv]
// ----------------------------------------------------------------------------
// sliding_window_variance: population variance over the last N samples
// Window store with running totals in front, a divider by N^2 behind it.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+---------------------------------
//  input    | i_in_valid / o_in_stall     | i_action, i_sample[23:0]
//  output   | o_out_valid / i_out_stall   | o_variance[46:0]
//  config   | i_cfg_wr_en                 | i_cfg_wr_data[6:0] (window size)
//
// The front end takes no new transaction until it has pushed the last one's job into the queue.
// Each result passes the back end's multiply, subtract, radix-4 divide and output states.
// Reset and a window length write clear the window to zeros at once.
// A stalled result holds the back end; the front end keeps filling the queue.
// ----------------------------------------------------------------------------
module sliding_window_variance import swv_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [LEN_W-1:0]           i_cfg_wr_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [VAR_W-1:0]           o_variance
);

    t_job push_job;
    t_job head_job;
    logic push;
    logic full;
    logic pop;
    logic empty;

    swv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_sample      (i_sample),
        .o_push        (push),
        .o_job         (push_job),
        .i_full        (full)
    );

    swv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (empty)
    );

    swv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_variance  (o_variance)
    );

endmodule

[design/swv_checker.sv]
// ----------------------------------------------------------------------------
// swv_checker: port-level checks for the sliding window variance block
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module swv_checker import swv_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_cfg_wr_en,
    input logic [LEN_W-1:0]           i_cfg_wr_data,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       i_action,
    input logic signed [SAMPLE_W-1:0] i_sample,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic [VAR_W-1:0]           o_variance
);

    localparam logic [VAR_W-1:0] VAR_LIMIT = VAR_W'(1) << (VAR_W - 1);

    // A waiting result must neither vanish nor change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_variance))
        else $error("result changed or dropped while stalled");

    // Reset leaves no result pending and the input side open.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("block not idle after reset");

    // The front end is busy in the cycle after it takes a transaction.
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken on two consecutive cycles");

    // The variance of 24-bit samples stays at or below 2^46.
    a_var_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_variance <= VAR_LIMIT)
        else $error("variance out of range");

endmodule

bind sliding_window_variance swv_checker u_swv_checker (.*);

[sim/tb_sliding_window_variance.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sliding_window_variance: self-checking bench for the window variance block
// Drives update and estimate transactions with random gaps, holds the result
// side off at random, and compares each variance against a behavioural copy
// of the window kept inside the bench. The window length is rewritten between
// phases, including the zero and saturating settings.
// ----------------------------------------------------------------------------
module tb_sliding_window_variance;
    import swv_pkg::*;

    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_wr_en = 1'b0;
    logic [LEN_W-1:0]           cfg_wr_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       in_action = ACT_UPDATE;
    logic signed [SAMPLE_W-1:0] in_sample = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [VAR_W-1:0]           out_variance;

    // Behavioural copy of the window.
    logic [LEN_W-1:0]           win_len = LEN_RESET;
    logic signed [SAMPLE_W-1:0] win_samples [MAX_WINDOW];
    int unsigned                win_pos;
    longint                     win_sum;
    longint unsigned            win_sq_sum;

    logic [VAR_W-1:0] variance_q [$];
    logic [VAR_W-1:0] expected_variance;
    int mismatches = 0;
    int stuck_cycles = 0;
    int send_gap_pct = 11;
    int recv_stall_pct = 81;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int hold_len = 0;

    sliding_window_variance i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_action      (in_action),
        .i_sample      (in_sample),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_variance    (out_variance)
    );

    always #1 clk = ~clk;

    function automatic void clear_window();
        for (int k = 0; k < MAX_WINDOW; k++) begin
            win_samples[k] = '0;
        end
        win_pos    = 0;
        win_sum    = 0;
        win_sq_sum = 0;
    endfunction

    // Variance of the window with the new sample in place of the oldest one.
    // Only an update commits the sample and moves the write position on.
    function automatic logic [VAR_W-1:0] window_variance(input t_action act,
            input logic signed [SAMPLE_W-1:0] smp);
        int unsigned     n;
        int unsigned     slot;
        longint          x;
        longint          old;
        longint          s;
        longint unsigned s2;
        longint unsigned num;
        longint unsigned q;
        n = (win_len == 0) ? 1 : ((win_len > MAX_WINDOW) ? MAX_WINDOW : win_len);
        slot = (win_pos >= n) ? 0 : win_pos;
        x   = smp;
        old = win_samples[slot];
        s   = win_sum - old + x;
        s2  = win_sq_sum - old * old + x * x;
        num = s2 * n - s * s;
        q   = num / (n * n);
        if (act == ACT_UPDATE) begin
            win_samples[slot] = smp;
            win_sum    = s;
            win_sq_sum = s2;
            slot++;
            win_pos = (slot >= n) ? 0 : slot;
        end
        return q[VAR_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(
            input logic signed [SAMPLE_W-1:0] prev);
        int unsigned                pick;
        logic signed [SAMPLE_W-1:0] v;
        pick = $urandom_range(99);
        if (pick < 5) begin
            v = SAMPLE_MAX;
        end else if (pick < 10) begin
            v = SAMPLE_MIN;
        end else if (pick < 22) begin
            v = prev;
        end else if (pick < 50) begin
            v = SAMPLE_W'($urandom_range(2000) - 1000);
        end else begin
            v = SAMPLE_W'($urandom);
        end
        return v;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    // with the valid still raised, so that a following item needs no toggle.
    task automatic send_item(input t_action act, input logic signed [SAMPLE_W-1:0] smp);
        if ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_sample <= smp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        variance_q.push_back(window_variance(act, smp));
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (variance_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_window_length(input logic [LEN_W-1:0] len);
        wait_results_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        win_len = len;
        clear_window();
    endtask

    task automatic run_segment(input logic [LEN_W-1:0] len, input int count);
        logic signed [SAMPLE_W-1:0] prev;
        logic signed [SAMPLE_W-1:0] smp;
        t_action                    act;
        write_window_length(len);
        prev = '0;
        repeat (count) begin
            smp = pick_sample(prev);
            if ($urandom_range(99) < 25) begin
                act = ACT_ESTIMATE;
            end else begin
                act = ACT_UPDATE;
            end
            send_item(act, smp);
            if (act == ACT_UPDATE) prev = smp;
        end
    endtask

    // Runs on the reset length of seven.
    task automatic test_directed_extremes();
        send_item(ACT_ESTIMATE, SAMPLE_MAX);
        send_item(ACT_ESTIMATE, SAMPLE_MIN);
        // Seven equal samples fill the window, so the variance falls to zero.
        repeat (7) send_item(ACT_UPDATE, SAMPLE_MAX);
        for (int k = 0; k < 6; k++) begin
            send_item(ACT_UPDATE, k[0] ? SAMPLE_MAX : SAMPLE_MIN);
        end
        send_item(ACT_ESTIMATE, '0);
        send_item(ACT_UPDATE, SAMPLE_W'(-1));
        send_item(ACT_ESTIMATE, SAMPLE_MIN);
    endtask

    task automatic test_length_edges();
        // A length of zero behaves as a window of one sample.
        write_window_length('0);
        send_item(ACT_UPDATE, SAMPLE_MAX);
        send_item(ACT_ESTIMATE, SAMPLE_MIN);
        // Lengths above the store size saturate to the full store.
        write_window_length(LEN_W'(MAX_WINDOW + 1));
        send_item(ACT_UPDATE, SAMPLE_MIN);
        send_item(ACT_UPDATE, SAMPLE_MAX);
        write_window_length('1);
        send_item(ACT_ESTIMATE, SAMPLE_MAX);
    endtask

    task automatic test_backpressure();
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_window_length(LEN_W'(5));
        hold_len = HOLD_CYCLES;
        hold_req++;
        run_segment(LEN_W'(5), 12);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 3; phase++) begin
            send_gap_pct   = (phase == 0) ? 11 : ((phase == 1) ? 81 : 0);
            recv_stall_pct = (phase == 0) ? 81 : ((phase == 1) ? 11 : 0);
            run_segment(LEN_W'(1), 60);
            run_segment(LEN_W'(MAX_WINDOW), 60);
            run_segment(LEN_W'($urandom_range(2, 8)), 60);
            run_segment(LEN_W'($urandom_range(9, MAX_WINDOW - 1)), 60);
            run_segment(LEN_W'($urandom_range(0, 127)), 60);
        end
    endtask

    // Result side: random stalls, plus a long hold-off when one is requested.
    always @(negedge clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = hold_len;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        if (out_valid && !out_stall) begin
            if (variance_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %0d", $time,
                         out_variance);
                mismatches++;
            end else begin
                expected_variance = variance_q.pop_front();
                if (out_variance !== expected_variance) begin
                    $display("%0t: variance mismatch, expected %0d, got %0d", $time,
                             expected_variance, out_variance);
                    mismatches++;
                end
            end
        end
        if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, stuck_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        clear_window();
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed_extremes();
        test_length_edges();
        test_backpressure();
        test_random_traffic();
        wait_results_drained();
        repeat (60) @(negedge clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
